FILE: design/osft_pkg.sv
// ----------------------------------------------------------------------------
// osft_pkg
// Shared types, constants and the multiply-accumulate step table of the
// observer / state-feedback torque block.
// ----------------------------------------------------------------------------
package osft_pkg;

    localparam int MEAS_W   = 24;             // Q11.12 measurement
    localparam int COEF_W   = 16;             // Q5.10 coefficient
    localparam int VAL_W    = 32;             // Q19.12 internal value
    localparam int TRQ_W    = 16;             // Q3.12 torque
    localparam int MAXT_W   = 15;
    localparam int BANK_W   = 64;
    localparam int BANKS    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W   = COEF_W + VAL_W; // 48
    localparam int ACC_W    = PROD_W + 2;     // up to six products per row
    localparam int FRAC_SH  = 10;             // Q.22 -> Q.12
    localparam int RAW_W    = ACC_W - FRAC_SH;
    localparam int STEP_W   = 5;

    localparam logic signed [ACC_W-1:0] ACC_INIT = ACC_W'(512); // rounding offset
    localparam logic [MAXT_W-1:0]       MAXT_RESET = 15'h7FFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TORQUE = 3'd7;

    // Step numbers of the sequence
    localparam logic [STEP_W-1:0] STEP_FIRST      = 5'd0;
    localparam logic [STEP_W-1:0] STEP_PRED_FIRST = 5'd18;
    localparam logic [STEP_W-1:0] STEP_PRED_LAST  = 5'd23;
    localparam logic [STEP_W-1:0] STEP_LAST       = 5'd26;

    typedef enum logic [3:0] {
        SRC_DRIVE = 4'd0,
        SRC_EST0  = 4'd1,
        SRC_EST1  = 4'd2,
        SRC_EST2  = 4'd3,
        SRC_INN0  = 4'd4,
        SRC_INN1  = 4'd5,
        SRC_NXT0  = 4'd6,
        SRC_NXT1  = 4'd7,
        SRC_NXT2  = 4'd8,
        SRC_RATE  = 4'd9,
        SRC_WHEEL = 4'd10
    } t_src;

    typedef enum logic [2:0] {
        DST_NONE   = 3'd0,
        DST_NXT0   = 3'd1,
        DST_NXT1   = 3'd2,
        DST_NXT2   = 3'd3,
        DST_PRED0  = 3'd4,
        DST_PRED1  = 3'd5,
        DST_TORQUE = 3'd6
    } t_dst;

    typedef struct packed {
        logic [STEP_W-1:0] coef;  // flat coefficient number
        t_src              src;
        t_dst              dst;   // row result target on the row's last step
    } t_op;

    // Update rows (B, A, L), prediction rows (C), then the gain row (K).
    function automatic t_op op_lookup(input logic [STEP_W-1:0] step);
        t_op op;
        unique case (step)
            5'd0:  op = '{5'd9,  SRC_DRIVE, DST_NONE};
            5'd1:  op = '{5'd0,  SRC_EST0,  DST_NONE};
            5'd2:  op = '{5'd1,  SRC_EST1,  DST_NONE};
            5'd3:  op = '{5'd2,  SRC_EST2,  DST_NONE};
            5'd4:  op = '{5'd18, SRC_INN0,  DST_NONE};
            5'd5:  op = '{5'd19, SRC_INN1,  DST_NXT0};
            5'd6:  op = '{5'd10, SRC_DRIVE, DST_NONE};
            5'd7:  op = '{5'd3,  SRC_EST0,  DST_NONE};
            5'd8:  op = '{5'd4,  SRC_EST1,  DST_NONE};
            5'd9:  op = '{5'd5,  SRC_EST2,  DST_NONE};
            5'd10: op = '{5'd20, SRC_INN0,  DST_NONE};
            5'd11: op = '{5'd21, SRC_INN1,  DST_NXT1};
            5'd12: op = '{5'd11, SRC_DRIVE, DST_NONE};
            5'd13: op = '{5'd6,  SRC_EST0,  DST_NONE};
            5'd14: op = '{5'd7,  SRC_EST1,  DST_NONE};
            5'd15: op = '{5'd8,  SRC_EST2,  DST_NONE};
            5'd16: op = '{5'd22, SRC_INN0,  DST_NONE};
            5'd17: op = '{5'd23, SRC_INN1,  DST_NXT2};
            5'd18: op = '{5'd12, SRC_NXT0,  DST_NONE};
            5'd19: op = '{5'd13, SRC_NXT1,  DST_NONE};
            5'd20: op = '{5'd14, SRC_NXT2,  DST_PRED0};
            5'd21: op = '{5'd15, SRC_NXT0,  DST_NONE};
            5'd22: op = '{5'd16, SRC_NXT1,  DST_NONE};
            5'd23: op = '{5'd17, SRC_NXT2,  DST_PRED1};
            5'd24: op = '{5'd24, SRC_NXT0,  DST_NONE};
            5'd25: op = '{5'd25, SRC_RATE,  DST_NONE};
            5'd26: op = '{5'd26, SRC_WHEEL, DST_TORQUE};
            default: op = '{5'd0, SRC_DRIVE, DST_NONE};
        endcase
        return op;
    endfunction

endpackage

FILE: design/osft_in_if.sv
// ----------------------------------------------------------------------------
// osft_in_if
// Sample channel: tilt angle, tilt rate, wheel rate and restart flag.
// ----------------------------------------------------------------------------
interface osft_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [osft_pkg::MEAS_W-1:0]  tilt_angle;
    logic signed [osft_pkg::MEAS_W-1:0]  tilt_rate;
    logic signed [osft_pkg::MEAS_W-1:0]  wheel_rate;
    logic                                restart;

    modport source (output valid, tilt_angle, tilt_rate, wheel_rate, restart, input ready);
    modport sink   (input valid, tilt_angle, tilt_rate, wheel_rate, restart, output ready);
endinterface

FILE: design/osft_out_if.sv
// ----------------------------------------------------------------------------
// osft_out_if
// Result channel: saturated drive torque.
// ----------------------------------------------------------------------------
interface osft_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [osft_pkg::TRQ_W-1:0]  torque;

    modport source (output valid, torque, input ready);
    modport sink   (input valid, torque, output ready);
endinterface

FILE: design/observer_state_feedback_torque_top.sv
// ----------------------------------------------------------------------------
// observer_state_feedback_torque_top
// Luenberger observer with state-feedback torque, one shared 16x32 MAC.
// A sample word is taken only while the block is idle. A seeding sample
// (first after reset, or restart set) runs the six C-row steps and returns
// zero torque. A regular sample runs 27 multiply-accumulate steps through
// the single MAC (18 for the estimate update, 6 for the output prediction,
// 3 for the gain row), then a pipeline drain state and a finish state. The
// finished torque sits in an output register, so the next sample is taken
// while a result waits. The user must write coefficient banks and max_torque
// through the plain write port only while no sample is in flight; the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
module observer_state_feedback_torque_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [osft_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [osft_pkg::BANK_W-1:0]         i_cfg_data,
    osft_in_if.sink                             i_in,
    osft_out_if.source                          o_out
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WAIT = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    localparam int VW = osft_pkg::VAL_W;
    localparam int MW = osft_pkg::MEAS_W;

    function automatic logic signed [VW-1:0] sat_val(
        input logic signed [osft_pkg::RAW_W-1:0] v);
        logic signed [osft_pkg::RAW_W-1:0] hi;
        logic signed [osft_pkg::RAW_W-1:0] lo;
        hi = osft_pkg::RAW_W'({1'b0, {(VW-1){1'b1}}});
        lo = -hi - osft_pkg::RAW_W'(1);
        if (v > hi) begin
            return {1'b0, {(VW-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(VW-1){1'b0}}};
        end
        return v[VW-1:0];
    endfunction

    // Configuration
    logic [osft_pkg::BANK_W-1:0]   r_bank [osft_pkg::BANKS];
    logic [osft_pkg::MAXT_W-1:0]   r_max;

    // Observer state
    logic signed [VW-1:0]              r_est  [3];
    logic signed [VW-1:0]              r_nxt  [3];
    logic signed [VW-1:0]              r_pred [2];
    logic signed [MW-1:0]              r_meas [2];
    logic signed [osft_pkg::TRQ_W-1:0] r_drive;
    logic                              r_first_run;

    // Sample and sequencer
    t_state                            r_state;
    logic                              r_seed;
    logic signed [MW-1:0]              r_rate;
    logic signed [MW-1:0]              r_wheel;
    logic signed [VW-1:0]              r_inn [2];
    logic [osft_pkg::STEP_W-1:0]       r_step;

    // MAC pipeline
    logic signed [osft_pkg::PROD_W-1:0] r_prod;
    osft_pkg::t_dst                     r_pdst;
    logic                               r_pvalid;
    logic signed [osft_pkg::ACC_W-1:0]  r_acc;
    logic signed [osft_pkg::RAW_W-1:0]  r_traw;

    // Result
    logic                               r_out_valid;
    logic signed [osft_pkg::TRQ_W-1:0]  r_torque;

    osft_pkg::t_op                      op;
    logic [osft_pkg::BANK_W-1:0]        bank_w;
    logic signed [osft_pkg::COEF_W-1:0] coef_w;
    logic signed [VW-1:0]               val_w;
    logic signed [VW:0]                 diff0;
    logic signed [VW:0]                 diff1;
    logic signed [VW-1:0]               inn0;
    logic signed [VW-1:0]               inn1;
    logic signed [osft_pkg::ACC_W-1:0]  acc_sum;
    logic signed [osft_pkg::RAW_W-1:0]  acc_q;
    logic signed [VW-1:0]               acc_sat;
    logic signed [osft_pkg::RAW_W:0]    tq_neg;
    logic signed [osft_pkg::RAW_W:0]    tq_lim;
    logic signed [osft_pkg::RAW_W:0]    tq_clamp;
    logic                               in_fire;
    logic                               fin_go;
    logic [osft_pkg::STEP_W-1:0]        last_step;

    assign in_fire   = i_in.valid && i_in.ready;
    assign fin_go    = (r_state == S_FIN) && (!r_out_valid || o_out.ready);
    assign last_step = r_seed ? osft_pkg::STEP_PRED_LAST : osft_pkg::STEP_LAST;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.torque = r_torque;

    // Operand fetch
    assign op     = osft_pkg::op_lookup(r_step);
    assign bank_w = r_bank[op.coef[4:2]];
    assign coef_w = bank_w[{op.coef[1:0], 4'b0000} +: osft_pkg::COEF_W];

    assign diff0 = (VW+1)'(r_meas[0]) - (VW+1)'(r_pred[0]);
    assign diff1 = (VW+1)'(r_meas[1]) - (VW+1)'(r_pred[1]);
    assign inn0  = sat_val(osft_pkg::RAW_W'(diff0));
    assign inn1  = sat_val(osft_pkg::RAW_W'(diff1));

    always_comb begin
        case (op.src)
            osft_pkg::SRC_DRIVE: val_w = VW'(r_drive);
            osft_pkg::SRC_EST0:  val_w = r_est[0];
            osft_pkg::SRC_EST1:  val_w = r_est[1];
            osft_pkg::SRC_EST2:  val_w = r_est[2];
            osft_pkg::SRC_INN0:  val_w = r_inn[0];
            osft_pkg::SRC_INN1:  val_w = r_inn[1];
            osft_pkg::SRC_NXT0:  val_w = r_nxt[0];
            osft_pkg::SRC_NXT1:  val_w = r_nxt[1];
            osft_pkg::SRC_NXT2:  val_w = r_nxt[2];
            osft_pkg::SRC_RATE:  val_w = VW'(r_rate);
            osft_pkg::SRC_WHEEL: val_w = VW'(r_wheel);
            default:             val_w = '0;
        endcase
    end

    // Accumulate; the row sum already carries the rounding offset
    assign acc_sum = r_acc + osft_pkg::ACC_W'(r_prod);
    assign acc_q   = acc_sum[osft_pkg::ACC_W-1:osft_pkg::FRAC_SH];
    assign acc_sat = sat_val(acc_q);

    // Torque: negate and clamp to +-max_torque
    assign tq_neg = -((osft_pkg::RAW_W+1)'(r_traw));
    assign tq_lim = (osft_pkg::RAW_W+1)'({1'b0, r_max});
    always_comb begin
        if (tq_neg > tq_lim) begin
            tq_clamp = tq_lim;
        end else if (tq_neg < -tq_lim) begin
            tq_clamp = -tq_lim;
        end else begin
            tq_clamp = tq_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < osft_pkg::BANKS; b++) begin
                r_bank[b] <= '0;
            end
            r_max <= osft_pkg::MAXT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == osft_pkg::CFG_MAX_TORQUE) begin
                r_max <= i_cfg_data[osft_pkg::MAXT_W-1:0];
            end else begin
                r_bank[i_cfg_idx] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pvalid    <= 1'b0;
            r_out_valid <= 1'b0;
            r_first_run <= 1'b1;
            r_drive     <= '0;
            r_acc       <= osft_pkg::ACC_INIT;
            r_step      <= osft_pkg::STEP_FIRST;
            r_seed      <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_est[i] <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                r_pred[i] <= '0;
                r_meas[i] <= '0;
            end
        end else begin
            r_pvalid <= (r_state == S_RUN);

            // Issue stage: one product per cycle
            r_prod <= coef_w * val_w;
            r_pdst <= op.dst;

            // Accumulate stage
            if (r_pvalid) begin
                if (r_pdst == osft_pkg::DST_NONE) begin
                    r_acc <= acc_sum;
                end else begin
                    r_acc <= osft_pkg::ACC_INIT;
                end
                case (r_pdst)
                    osft_pkg::DST_NXT0:   r_nxt[0]  <= acc_sat;
                    osft_pkg::DST_NXT1:   r_nxt[1]  <= acc_sat;
                    osft_pkg::DST_NXT2:   r_nxt[2]  <= acc_sat;
                    osft_pkg::DST_PRED0:  r_pred[0] <= acc_sat;
                    osft_pkg::DST_PRED1:  r_pred[1] <= acc_sat;
                    osft_pkg::DST_TORQUE: r_traw    <= acc_q;
                    default: ;
                endcase
            end

            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_rate  <= i_in.tilt_rate;
                        r_wheel <= i_in.wheel_rate;
                        // hold the innovation while measurement and prediction are stable
                        r_inn[0] <= inn0;
                        r_inn[1] <= inn1;
                        r_acc   <= osft_pkg::ACC_INIT;
                        r_state <= S_RUN;
                        if (r_first_run || i_in.restart) begin
                            // seed the estimate and run the prediction rows only
                            r_seed   <= 1'b1;
                            r_nxt[0] <= VW'(i_in.tilt_angle);
                            r_nxt[1] <= VW'(i_in.tilt_rate);
                            r_nxt[2] <= VW'(i_in.wheel_rate);
                            r_step   <= osft_pkg::STEP_PRED_FIRST;
                        end else begin
                            r_seed <= 1'b0;
                            r_step <= osft_pkg::STEP_FIRST;
                        end
                    end
                end
                S_RUN: begin
                    if (r_step == last_step) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_step <= r_step + osft_pkg::STEP_W'(1);
                    end
                end
                S_WAIT: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_first_run <= 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            r_est[i] <= r_nxt[i];
                        end
                        r_meas[0] <= r_rate;
                        r_meas[1] <= r_wheel;
                        if (r_seed) begin
                            r_torque <= '0;
                            r_drive  <= '0;
                        end else begin
                            r_torque <= tq_clamp[osft_pkg::TRQ_W-1:0];
                            r_drive  <= tq_clamp[osft_pkg::TRQ_W-1:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // Delivered torque never exceeds the clamp magnitude
    a_torque_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
            ($signed({o_out.torque[osft_pkg::TRQ_W-1], o_out.torque})
                <= $signed({2'b00, r_max}))
            && ($signed({o_out.torque[osft_pkg::TRQ_W-1], o_out.torque})
                >= -$signed({2'b00, r_max})))
        else $error("torque outside clamp range");

    // MAC accumulate stage only follows issue cycles
    a_mac_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pvalid |-> (r_state == S_RUN || r_state == S_WAIT))
        else $error("accumulate outside of sequence");

    // A finished word always leaves the observer seeded
    a_seeded_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go |=> (!r_first_run && r_out_valid && r_state == S_IDLE))
        else $error("finish did not commit");
`endif

endmodule
